@@ design/rpn_pkg.sv @@
// Shared types and constants for the reverse Polish stack calculator.
// Symbol codes, status codes and the request to the shared arithmetic unit.
// No dependencies.
package rpn_pkg;

	// Character codes of the recognised symbols
	localparam logic [7:0] SYM_0    = 8'h30;
	localparam logic [7:0] SYM_9    = 8'h39;
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_SWAP = 8'h73;
	localparam logic [7:0] SYM_DOWN = 8'h64;
	localparam logic [7:0] SYM_UP   = 8'h75;

	// Status codes returned with each result
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDER   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	// Request from the sequencer to the arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

@@ design/rpn_store.sv @@
// Ring store of stack values: one write port, one registered read port.
// Depends on nothing; depth and address width are set by the top level.
module rpn_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/rpn_alu.sv @@
// Shared arithmetic unit: add, subtract and multiply, and signed truncating
// division one quotient bit a cycle. Uses rpn_pkg.
module rpn_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::alu_req_t req,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic              done,
	output logic [31:0]       result
);
	import rpn_pkg::*;

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_DIV  = 4'b0010,
		A_SIGN = 4'b0100,
		A_DONE = 4'b1000
	} alu_state_t;

	alu_state_t  state_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] mb_q;
	logic        neg_q;
	logic [31:0] result_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] trial;
	logic [31:0] quick;

	// Operand magnitudes, one restoring step and the add, subtract or multiply result
	always_comb begin
		ma    = a[31] ? (32'd0 - a) : a;
		mb    = b[31] ? (32'd0 - b) : b;
		trial = {rem_q, quo_q[31]} - {1'b0, mb_q};
		case (req.op)
			ALU_ADD: quick = a + b;
			ALU_SUB: quick = a - b;
			default: quick = a * b;
		endcase
	end

	// Advance the unit's state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= (req.op == ALU_DIV) ? A_DIV : A_DONE;
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= A_SIGN;
					end
				end
				A_SIGN:  state_q <= A_DONE;
				A_DONE:  state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Hold operands, sign, partial remainder, quotient and result
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					rem_q    <= '0;
					quo_q    <= ma;
					mb_q     <= mb;
					neg_q    <= a[31] ^ b[31];
					result_q <= quick;
				end
			end
			A_DIV: begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			A_SIGN: begin
				result_q <= neg_q ? (32'd0 - quo_q) : quo_q;
			end
			default: ;
		endcase
	end

	assign done   = (state_q == A_DONE);
	assign result = result_q;

endmodule

@@ design/rpn_stack_calculator.sv @@
// Reverse Polish stack calculator: sequencer, ring store and shared ALU.
// Depends on rpn_pkg, rpn_store and rpn_alu.
//
//   Channel   Handshake              Payload
//   input     start & !busy          symbol[7:0]
//   result    valid (one cycle)      top_value[31:0] signed, depth[4:0], status[1:0]
//
// Divide is the longest item: the 32 quotient steps of the shared divider set
// its length.
// Every store access goes through the single write port and registered read port.
// After reset the stack is empty; the store needs no clearing pass.
// A result is shown for exactly one cycle; the receiver cannot stall it.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         symbol,
	output logic               valid,
	output logic signed [31:0] top_value,
	output logic [4:0]         depth,
	output logic [1:0]         status
);
	import rpn_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_DECODE = 8'b00000010,
		S_RD1    = 8'b00000100,
		S_RD2    = 8'b00001000,
		S_SWAP   = 8'b00010000,
		S_EXEC   = 8'b00100000,
		S_FETCH  = 8'b01000000,
		S_EMIT   = 8'b10000000
	} seq_state_t;

	// Ring index: (base + offset) mod depth, for a base below the depth and an offset up to it
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		begin
			sum = SW'(base) + SW'(off);
			if (sum >= SW'(STACK_DEPTH)) begin
				sum = sum - SW'(STACK_DEPTH);
			end
			return sum[AW-1:0];
		end
	endfunction

	seq_state_t    state_q, state_d;
	logic [7:0]    sym_q;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] bottom_q, bottom_d;
	logic [1:0]    status_q, status_d;
	logic [31:0]   first_q, first_d;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	alu_req_t      alu_req;
	logic          alu_done;
	logic [31:0]   alu_result;

	logic [AW-1:0] top_slot, sec_slot, push_slot, bot_next, bot_prev;
	logic          is_digit, is_arith, is_swap, is_down, is_up;
	logic          two_plus, full;
	alu_op_t       arith_op;

	// Decode the held symbol and the ring positions
	always_comb begin
		top_slot  = slot(bottom_q, count_q - CW'(1));
		sec_slot  = slot(bottom_q, count_q - CW'(2));
		push_slot = slot(bottom_q, count_q);
		bot_next  = slot(bottom_q, CW'(1));
		bot_prev  = (bottom_q == '0) ? AW'(STACK_DEPTH - 1) : (bottom_q - AW'(1));
		is_digit  = (sym_q >= SYM_0) && (sym_q <= SYM_9);
		is_arith  = (sym_q == SYM_ADD) || (sym_q == SYM_SUB) ||
			(sym_q == SYM_MUL) || (sym_q == SYM_DIV);
		is_swap   = (sym_q == SYM_SWAP);
		is_down   = (sym_q == SYM_DOWN);
		is_up     = (sym_q == SYM_UP);
		two_plus  = (count_q >= CW'(2));
		full      = (count_q >= CW'(STACK_DEPTH));
		case (sym_q)
			SYM_ADD: arith_op = ALU_ADD;
			SYM_SUB: arith_op = ALU_SUB;
			SYM_MUL: arith_op = ALU_MUL;
			default: arith_op = ALU_DIV;
		endcase
	end

	// Sequence the store accesses and the ALU
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		bottom_d      = bottom_q;
		status_d      = status_q;
		first_d       = first_q;
		mem_we        = 1'b0;
		mem_waddr     = top_slot;
		mem_wdata     = first_q;
		mem_re        = 1'b0;
		mem_raddr     = top_slot;
		alu_req.start = 1'b0;
		alu_req.op    = arith_op;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					status_d = ST_OK;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FETCH;
				if (is_digit) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = push_slot;
						mem_wdata = 32'(sym_q - SYM_0);
						count_d   = count_q + CW'(1);
					end
				end else if (is_arith && !two_plus) begin
					status_d = ST_UNDER;
				end else if ((is_arith || is_swap || is_down || is_up) && two_plus) begin
					mem_re    = 1'b1;
					mem_raddr = is_down ? bottom_q : top_slot;
					state_d   = S_RD1;
				end
			end
			S_RD1: begin
				first_d = mem_rdata;
				if (is_down) begin
					mem_we    = 1'b1;
					mem_waddr = push_slot;
					mem_wdata = mem_rdata;
					bottom_d  = bot_next;
					state_d   = S_FETCH;
				end else if (is_up) begin
					mem_we    = 1'b1;
					mem_waddr = bot_prev;
					mem_wdata = mem_rdata;
					bottom_d  = bot_prev;
					state_d   = S_FETCH;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = sec_slot;
					state_d   = S_RD2;
				end
			end
			S_RD2: begin
				if (is_swap) begin
					mem_we    = 1'b1;
					mem_waddr = top_slot;
					mem_wdata = mem_rdata;
					state_d   = S_SWAP;
				end else if ((sym_q == SYM_DIV) && (first_q == '0)) begin
					status_d = ST_DIVZERO;
					state_d  = S_FETCH;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = sec_slot;
				mem_wdata = first_q;
				state_d   = S_FETCH;
			end
			S_EXEC: begin
				if (alu_done) begin
					mem_we    = 1'b1;
					mem_waddr = sec_slot;
					mem_wdata = alu_result;
					count_d   = count_q - CW'(1);
					state_d   = S_FETCH;
				end
			end
			S_FETCH: begin
				mem_re    = (count_q != '0);
				mem_raddr = top_slot;
				state_d   = S_EMIT;
			end
			S_EMIT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			bottom_q <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			bottom_q <= bottom_d;
			status_q <= status_d;
		end
	end

	// Hold the symbol and the first operand
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sym_q <= symbol;
		end
		first_q <= first_d;
	end

	rpn_store #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Operand a is the second value, b the top value
	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (mem_rdata),
		.b      (first_q),
		.done   (alu_done),
		.result (alu_result)
	);

	// Drive the result transfer
	assign busy      = (state_q != S_IDLE);
	assign valid     = (state_q == S_EMIT);
	assign top_value = (count_q == '0) ? 32'sd0 : signed'(mem_rdata);
	assign depth     = 5'(count_q);
	assign status    = status_q;

endmodule

@@ test/tb_rpn_stack_calculator.sv @@
// Self-checking testbench for the reverse Polish stack calculator.
// Depends on rpn_pkg and rpn_stack_calculator; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;
	import rpn_pkg::*;

	localparam int CALC_DEPTH = 16;

	// One expected result of the calculator
	typedef struct {
		logic signed [31:0] top;
		logic [4:0]         depth;
		logic [1:0]         status;
	} calc_result_t;

	// Predict the stack after each transfer and check results in order
	class stack_scoreboard;
		localparam int DEPTH = CALC_DEPTH;
		logic [31:0]  ring [DEPTH];
		int unsigned  bottom;
		int unsigned  held;
		int unsigned  failures;
		calc_result_t expected_results [$];

		function new();
			foreach (ring[i]) ring[i] = '0;
			bottom = 0;
			held = 0;
			failures = 0;
		endfunction

		function int unsigned slot(int unsigned offset);
			return (bottom + offset) % DEPTH;
		endfunction

		task report(string msg);
			failures++;
			if (failures <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		function void note_symbol(logic [7:0] sym);
			logic signed [31:0] upper;
			logic signed [31:0] lower;
			logic signed [31:0] outcome;
			logic [1:0]         code;
			calc_result_t       exp_r;
			code = ST_OK;
			if (sym >= SYM_0 && sym <= SYM_9) begin
				// push a digit unless the ring is full
				if (held >= DEPTH) begin
					code = ST_FULL;
				end else begin
					ring[slot(held)] = 32'(sym - SYM_0);
					held++;
				end
			end else if (sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV}) begin
				// pop two, push second op top; errors leave the stack alone
				if (held < 2) begin
					code = ST_UNDER;
				end else begin
					upper = ring[slot(held - 1)];
					lower = ring[slot(held - 2)];
					if (sym == SYM_DIV && upper == 0) begin
						code = ST_DIVZERO;
					end else begin
						case (sym)
							SYM_ADD: outcome = lower + upper;
							SYM_SUB: outcome = lower - upper;
							SYM_MUL: outcome = lower * upper;
							// most negative over minus one wraps back to itself
							default: outcome = (upper == -1) ? -lower : lower / upper;
						endcase
						ring[slot(held - 2)] = outcome;
						held--;
					end
				end
			end else if (sym == SYM_SWAP) begin
				if (held >= 2) begin
					upper = ring[slot(held - 1)];
					ring[slot(held - 1)] = ring[slot(held - 2)];
					ring[slot(held - 2)] = upper;
				end
			end else if (sym == SYM_DOWN) begin
				// bottom value goes on top: copy it past the top, advance the base
				if (held >= 2) begin
					ring[slot(held)] = ring[slot(0)];
					bottom = slot(1);
				end
			end else if (sym == SYM_UP) begin
				// top value goes under the bottom: step the base back and copy
				if (held >= 2) begin
					upper = ring[slot(held - 1)];
					bottom = slot(DEPTH - 1);
					ring[bottom] = upper;
				end
			end
			exp_r.top = (held == 0) ? '0 : ring[slot(held - 1)];
			exp_r.depth = 5'(held);
			exp_r.status = code;
			expected_results.push_back(exp_r);
		endfunction

		task check_result(logic signed [31:0] top, logic [4:0] depth, logic [1:0] status);
			calc_result_t exp_r;
			if (expected_results.size() == 0) begin
				report($sformatf("result top=%0d depth=%0d status=%0d with none expected",
					top, depth, status));
			end else begin
				exp_r = expected_results.pop_front();
				if (top !== exp_r.top)
					report($sformatf("top_value %0d, expected %0d", top, exp_r.top));
				if (depth !== exp_r.depth)
					report($sformatf("depth %0d, expected %0d", depth, exp_r.depth));
				if (status !== exp_r.status)
					report($sformatf("status %0d, expected %0d", status, exp_r.status));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start = 1'b0;
	logic               busy;
	logic [7:0]         symbol = '0;
	logic               valid;
	logic signed [31:0] top_value;
	logic [4:0]         depth;
	logic [1:0]         status;

	bit no_idle = 1'b0;

	stack_scoreboard sb = new();

	rpn_stack_calculator #(
		.STACK_DEPTH(CALC_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.symbol(symbol),
		.valid(valid),
		.top_value(top_value),
		.depth(depth),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hold start until the transfer, idling at random on the way
	task automatic send_symbol(input logic [7:0] sym);
		bit done = 1'b0;
		while (!done) begin
			if (!no_idle && $urandom_range(99) < 36) begin
				start <= 1'b0;
				symbol <= 8'($urandom);
				@(posedge clk);
			end else begin
				start <= 1'b1;
				symbol <= sym;
				@(posedge clk);
				done = !busy;
			end
		end
		sb.note_symbol(sym);
	endtask

	// Check every result in the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && valid) sb.check_result(top_value, depth, status);
	end

	initial begin
		logic [7:0] sym;
		int         useful;
		int         roll;
		int         pick;
		int         waited;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: errors and no-ops on a short stack
		send_symbol(SYM_ADD);
		send_symbol(8'hFF);
		send_symbol(8'h00);
		send_symbol(SYM_0 + 8'd8);
		send_symbol(SYM_SWAP);
		send_symbol(SYM_DOWN);
		send_symbol(SYM_UP);
		send_symbol(SYM_MUL);
		// build two to the 31st, which wraps to the most negative value
		repeat (9) begin
			send_symbol(SYM_0 + 8'd8);
			send_symbol(SYM_MUL);
		end
		send_symbol(SYM_0 + 8'd2);
		send_symbol(SYM_MUL);
		send_symbol(SYM_0);
		send_symbol(SYM_DIV);
		send_symbol(SYM_0 + 8'd1);
		send_symbol(SYM_SUB);
		send_symbol(SYM_DIV);
		send_symbol(SYM_9);
		send_symbol(SYM_ADD);

		// Random part: mostly well-formed programs, some noise and stack fills
		useful = 0;
		while (useful < 650) begin
			no_idle = (useful >= 280 && useful < 420);
			roll = $urandom_range(99);
			if (roll < 5) begin
				sym = 8'($urandom);
			end else if (roll < 8) begin
				while (sb.held < CALC_DEPTH) begin
					send_symbol(SYM_0 + 8'($urandom_range(9)));
					useful++;
				end
				sym = SYM_0 + 8'($urandom_range(9));
			end else if (sb.held < 2 && roll < 90) begin
				sym = SYM_0 + 8'($urandom_range(9));
			end else begin
				pick = $urandom_range(99);
				if (pick < 38) begin
					sym = SYM_0 + 8'($urandom_range(9));
				end else if (pick < 82) begin
					case ($urandom_range(3))
						0: sym = SYM_ADD;
						1: sym = SYM_SUB;
						2: sym = SYM_MUL;
						default: sym = SYM_DIV;
					endcase
				end else begin
					case ($urandom_range(2))
						0: sym = SYM_SWAP;
						1: sym = SYM_DOWN;
						default: sym = SYM_UP;
					endcase
				end
			end
			send_symbol(sym);
			if ((sym >= SYM_0 && sym <= SYM_9) ||
				sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_SWAP, SYM_DOWN, SYM_UP})
				useful++;
		end
		start <= 1'b0;

		// Drain outstanding results, then allow for a late stray one
		waited = 0;
		while (sb.expected_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (48) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
		if (sb.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
